// File: rtl/totp_pkg.sv
// Shared types, constants and the decimal modulus table for the TOTP block.
package totp_pkg;

  // Field widths of the request and result items
  localparam int TIME_W  = 63;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 27;
  localparam int STEP_W  = 16;
  localparam int DIGIT_W = 4;

  // Divider: one quotient bit per step across the full time width
  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Four bytes make up the truncated word
  localparam int TRUNC_BYTES = 4;

  // Configuration register indexes
  localparam logic CFG_TIME_STEP   = 1'b0;
  localparam logic CFG_DIGIT_COUNT = 1'b1;

  // Register reset values
  localparam logic [STEP_W-1:0]  TIME_STEP_RST   = 16'd30;
  localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RST = 4'd6;

  // Item kinds
  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] time_seconds;
    logic [BYTE_W-1:0] response_byte;
    logic              last_byte;
  } totp_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [TIME_W-1:0] moving_counter;
    logic [CODE_W-1:0] otp_code;
  } totp_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       store_byte;
    logic       div_load;
    logic       div_sel_code;
    logic       div_step;
    logic       rd_issue;
    logic [1:0] rd_sel;
    logic       rd_take;
    logic       clear_store;
    logic       out_load;
  } totp_cmd_t;

  // 10^digits, digit count saturating at eight, zero digits giving 1
  function automatic logic [CODE_W-1:0] pow10(input logic [DIGIT_W-1:0] dc);
    logic [CODE_W-1:0] p;
    unique case (dc)
      4'd0:    p = 27'd1;
      4'd1:    p = 27'd10;
      4'd2:    p = 27'd100;
      4'd3:    p = 27'd1000;
      4'd4:    p = 27'd10000;
      4'd5:    p = 27'd100000;
      4'd6:    p = 27'd1000000;
      4'd7:    p = 27'd10000000;
      default: p = 27'd100000000;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/totp_ctrl.sv
// Controller: sequences store writes, truncation reads, divider steps and result hand-off.
module totp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  input  logic                in_last,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output totp_pkg::totp_cmd_t cmd
);
  import totp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_LOADC = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TIME) begin
            cmd.div_load = 1'b1;
            state_nxt    = S_DIV;
            cnt_nxt      = '0;
          end else begin
            cmd.store_byte = 1'b1;
            if (in_last) begin
              state_nxt = S_READ;
              cnt_nxt   = '0;
            end
          end
        end
      end
      S_READ: begin
        // addresses go out on counts 0..3, the registered read data is taken on counts 1..4
        cmd.rd_issue = (cnt_r < CNT_W'(TRUNC_BYTES));
        cmd.rd_sel   = cnt_r[1:0];
        cmd.rd_take  = (cnt_r != '0);
        if (cnt_r == CNT_W'(TRUNC_BYTES)) begin
          state_nxt = S_LOADC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LOADC: begin
        cmd.div_load     = 1'b1;
        cmd.div_sel_code = 1'b1;
        cmd.clear_store  = 1'b1;
        state_nxt        = S_DIV;
        cnt_nxt          = '0;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/totp_dpath.sv
// Datapath: config registers, response store, truncation word and radix-2 divider.
module totp_dpath #(
  parameter int HMAC_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  totp_pkg::totp_in_t  in_data,
  input  totp_pkg::totp_cmd_t cmd,
  output totp_pkg::totp_out_t out_data
);
  import totp_pkg::*;

  localparam int AW  = $clog2(HMAC_BYTES);
  localparam int BCW = $clog2(HMAC_BYTES + 1);

  logic [STEP_W-1:0]  time_step_r;
  logic [DIGIT_W-1:0] digit_count_r;

  logic [BYTE_W-1:0]  mem [HMAC_BYTES];
  logic [HMAC_BYTES-1:0] vld_r;
  logic [BCW-1:0]     byte_cnt_r;
  logic [BYTE_W-1:0]  last_kept_r;
  logic [BYTE_W-1:0]  rd_data_r;
  logic               rd_vld_r;
  logic [31:0]        raw_r;

  logic               store_ok;
  logic [AW-1:0]      wr_addr;
  logic [4:0]         rd_sum;
  logic [AW-1:0]      rd_addr;

  logic [TIME_W-1:0]  dvd_r;
  logic [CODE_W-1:0]  dvs_r;
  logic [CODE_W-1:0]  rem_r;
  logic               kind_r;
  logic [CODE_W:0]    trial;
  logic [CODE_W:0]    diff;
  logic               ge;
  logic [CODE_W-1:0]  step_dvs;

  totp_out_t out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= TIME_STEP_RST;
      digit_count_r <= DIGIT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step_r   <= cfg_wdata;
        CFG_DIGIT_COUNT: digit_count_r <= cfg_wdata[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Response store: bytes past the end are dropped
  assign store_ok = cmd.store_byte && (byte_cnt_r < BCW'(HMAC_BYTES));
  assign wr_addr  = byte_cnt_r[AW-1:0];
  assign rd_sum   = 5'(last_kept_r[3:0]) + 5'(cmd.rd_sel);
  assign rd_addr  = AW'(rd_sum);

  always_ff @(posedge clk) begin
    if (store_ok) mem[wr_addr] <= in_data.response_byte;
    if (cmd.rd_issue) rd_data_r <= mem[rd_addr];
  end

  // Per-entry valid bits stand in for clearing the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      byte_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (cmd.clear_store) begin
        vld_r      <= '0;
        byte_cnt_r <= '0;
      end else if (store_ok) begin
        vld_r[wr_addr] <= 1'b1;
        byte_cnt_r     <= byte_cnt_r + 1'b1;
      end
      if (cmd.rd_issue) rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Final kept byte gives the offset
  always_ff @(posedge clk) begin
    if (store_ok) last_kept_r <= in_data.response_byte;
  end

  // Truncation word, most significant byte first
  always_ff @(posedge clk) begin
    if (cmd.rd_take) raw_r <= {raw_r[23:0], (rd_vld_r ? rd_data_r : 8'h00)};
  end

  // Divisor selection: a zero step counts as one
  always_comb begin
    if (time_step_r == '0) step_dvs = CODE_W'(1);
    else                   step_dvs = CODE_W'(time_step_r);
  end

  // Restoring divider, one quotient bit per step
  assign trial = {rem_r, dvd_r[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= '0;
      kind_r <= cmd.div_sel_code;
      if (cmd.div_sel_code) begin
        dvd_r <= TIME_W'(raw_r[30:0]);
        dvs_r <= pow10(digit_count_r);
      end else begin
        dvd_r <= in_data.time_seconds;
        dvs_r <= step_dvs;
      end
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[CODE_W-1:0] : trial[CODE_W-1:0];
      dvd_r <= {dvd_r[TIME_W-2:0], ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.result_kind    <= kind_r;
      out_data_r.moving_counter <= kind_r ? '0 : dvd_r;
      out_data_r.otp_code       <= kind_r ? rem_r : '0;
    end
  end

  assign out_data = out_data_r;

endmodule

// File: rtl/totp_counter_and_truncation_top.sv
// Top level: TOTP moving counter and HOTP dynamic truncation.
//
//   channel | ports                          | carries
//   --------+--------------------------------+------------------------------------
//   in      | in_valid, in_stall, in_data    | time sample or one HMAC response byte
//   out     | out_valid, out_stall, out_data | moving counter or one-time code
//   cfg     | cfg_we, cfg_index, cfg_wdata   | time step, digit count
//
// Time item: divider load, divider steps across the full time width, hand-off.
// Last response byte: adds four store reads through a read data register and a
// code load first. Other response bytes are taken without a stall. The shared radix-2
// divider, one quotient bit per cycle, serves both kinds of item.
// Reset is synchronous; the store's valid bits clear at once, no clearing pass.
// A finished result waits in the output register while a new request is taken;
// the next result waits in the divider while the output stays stalled.
module totp_counter_and_truncation_top #(
  parameter int HMAC_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  totp_pkg::totp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output totp_pkg::totp_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import totp_pkg::*;

  totp_cmd_t cmd;

  totp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_last   (in_data.last_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  totp_dpath #(
    .HMAC_BYTES (HMAC_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// File: rtl/totp_checker.sv
// Port-level checker for the TOTP block, bound to the top level.
module totp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input totp_pkg::totp_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input totp_pkg::totp_out_t out_data
);
  import totp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A time request keeps the block busy
  a_time_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind == KIND_TIME) |=> in_stall)
    else $error("block free right after a time request");

  // A non-final response byte leaves the input unstalled in the cycle after it
  a_byte_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind == KIND_RESP) && !in_data.last_byte
    |=> !in_stall)
    else $error("block busy after a plain response byte");

  // Result fields match the result kind
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == KIND_TIME && out_data.otp_code == '0) ||
                  (out_data.result_kind == KIND_RESP && out_data.moving_counter == '0 &&
                   out_data.otp_code < 27'd100000000))
    else $error("result fields do not match result kind");

  // Nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind totp_counter_and_truncation_top totp_checker u_totp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
